FILE: sv/fnp_pkg.sv
// Shared types and constants for the fretboard note placement block.
package fnp_pkg;

    localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
    localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;
    localparam logic [1:0] FUNC_READ     = 2'd3;

    localparam int TUNING_REGS = 6;
    localparam logic [2:0] CAPO_REG = 3'd6;

    localparam int NOTE_W = 7;
    localparam int FRET_W = 5;
    localparam int MASK_W = 16;

    typedef struct packed {
        logic              ok;
        logic              busy;
        logic [FRET_W-1:0] fret;
    } eval_t;

    function automatic logic [NOTE_W-1:0] tuning_reset(input int idx);
        logic [NOTE_W-1:0] val;
        case (idx)
            0: val = 7'd40;
            1: val = 7'd45;
            2: val = 7'd50;
            3: val = 7'd55;
            4: val = 7'd59;
            5: val = 7'd64;
            default: val = 7'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: sv/fnp_row_mem.sv
// One row per string of channel masks, registered read, per-row valid bits.
module fnp_row_mem #(
    parameter int DEPTH  = 6,
    parameter int WIDTH  = 400,
    parameter int ADDR_W = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clr,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: sv/fnp_string_unit.sv
// Shared per-string unit: fret, validity, busy test and row update.
module fnp_string_unit #(
    parameter int FRET_COUNT   = 25,
    parameter int CHANNEL_BITS = 16
) (
    input  logic [1:0]                           func,
    input  logic [CHANNEL_BITS-1:0]              ch,
    input  logic [fnp_pkg::NOTE_W-1:0]           note,
    input  logic [fnp_pkg::NOTE_W-1:0]           tuning,
    input  logic [fnp_pkg::FRET_W-1:0]           capo,
    input  logic [fnp_pkg::FRET_W-1:0]           mod_fret,
    input  logic [FRET_COUNT*CHANNEL_BITS-1:0]   row,
    output fnp_pkg::eval_t                       eval,
    output logic [FRET_COUNT*CHANNEL_BITS-1:0]   new_row,
    output logic [CHANNEL_BITS-1:0]              cell_data
);

    logic [fnp_pkg::NOTE_W:0]   diff;
    logic [fnp_pkg::FRET_W-1:0] tgt;

    assign diff = {1'b0, note} - {1'b0, tuning};

    always_comb begin
        eval.ok   = !diff[fnp_pkg::NOTE_W]
                    && diff[fnp_pkg::NOTE_W-1:0] >= {2'b00, capo}
                    && diff[fnp_pkg::NOTE_W-1:0] < 7'(FRET_COUNT);
        eval.busy = |(row & {FRET_COUNT{ch}});
        eval.fret = diff[fnp_pkg::FRET_W-1:0];
    end

    assign tgt = (func == fnp_pkg::FUNC_NOTE_OFF) ? eval.fret : mod_fret;

    always_comb begin
        logic                    hit;
        logic [CHANNEL_BITS-1:0] old;
        cell_data = '0;
        new_row   = row;
        for (int f = 0; f < FRET_COUNT; f++) begin
            hit = (tgt == 5'(f));
            old = row[f*CHANNEL_BITS +: CHANNEL_BITS];
            if (hit) begin
                cell_data = old;
            end
            case (func)
                fnp_pkg::FUNC_NOTE_ON: begin
                    if (hit) begin
                        new_row[f*CHANNEL_BITS +: CHANNEL_BITS] = old | ch;
                    end
                end
                fnp_pkg::FUNC_NOTE_OFF: begin
                    if (hit && eval.ok) begin
                        new_row[f*CHANNEL_BITS +: CHANNEL_BITS] = old & ~ch;
                    end
                end
                fnp_pkg::FUNC_ALL_OFF: begin
                    new_row[f*CHANNEL_BITS +: CHANNEL_BITS] = old & ~ch;
                end
                default: begin
                    new_row[f*CHANNEL_BITS +: CHANNEL_BITS] = old;
                end
            endcase
        end
    end

endmodule

FILE: sv/fretboard_note_placement_top.sv
// Top level: fretboard note placement with sequencer and APB register file.
//
// Input channel (s_*): one event per transfer - note on, note off, all notes
// off or read cell. Result channel (m_*): exactly one result per event.
// Registers: tuning_0..5 at byte addresses 0..20, capo at 24, over APB.
// One shared string unit walks the strings in turn, each in a row read
// state and an evaluate/write state, so the row memory port sets the pace.
// A placed note on ends with a read and write-back of the chosen string;
// note off and all off write each string as it is evaluated; a read visits
// only the selected string, or none when the cell lies outside the board.
// One event at a time: s_ready is high only when the sequencer is idle, from
// the cycle m_valid rises, so a new event is taken only once the result of
// the last one has reached the output register.
// A finished result waits in the output register; the next event is taken
// meanwhile, and its result is held back until the receiver takes the first.
// Reset restores default tuning and capo and empties the board at once
// (row valid bits, no clearing pass); any accepted register write also empties the board.
module fretboard_note_placement_top #(
    parameter int NUM_STRINGS  = 6,
    parameter int FRET_COUNT   = 25,
    parameter int CHANNEL_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_channels,
    input  logic [6:0]  s_note,
    input  logic [2:0]  s_string_sel,
    input  logic [4:0]  s_fret_sel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_placed,
    output logic [2:0]  m_string_out,
    output logic [4:0]  m_fret_out,
    output logic [15:0] m_cell_mask,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIW = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;
    localparam int RW  = FRET_COUNT * CHANNEL_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_BRD  = 3'd3;
    localparam logic [2:0] ST_BWR  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [6:0] tuning_reg [NUM_STRINGS];
    logic [4:0] capo_reg;

    logic [2:0] state_reg, state_next;
    logic [1:0] func_reg;
    logic [CHANNEL_BITS-1:0] ch_reg;
    logic [6:0] note_reg;
    logic [4:0] fsel_reg;
    logic [SIW-1:0] addr_reg, addr_next;
    logic found_reg, found_next;
    logic [SIW-1:0] best_str_reg, best_str_next;
    logic [4:0] best_fret_reg, best_fret_next;
    logic [5:0] best_key_reg, best_key_next;
    logic [CHANNEL_BITS-1:0] cell_reg, cell_next;

    logic s_xfer, m_xfer, last, better, in_range, mem_we;
    logic [5:0] key_now;
    logic [4:0] mod_fret;
    logic [RW-1:0] row, new_row;
    logic [CHANNEL_BITS-1:0] cell_data;
    fnp_pkg::eval_t eval;

    logic       cfg_we, tuning_hit, capo_ok, cfg_clr;
    logic [2:0] cfg_idx;

    // register file
    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite;
    assign cfg_idx    = paddr[4:2];
    assign tuning_hit = cfg_idx < 3'(fnp_pkg::TUNING_REGS)
                        && {1'b0, cfg_idx} < 4'(NUM_STRINGS);
    assign capo_ok    = cfg_idx == fnp_pkg::CAPO_REG
                        && {1'b0, pwdata[4:0]} < 6'(FRET_COUNT);
    assign cfg_clr    = cfg_we && (tuning_hit || capo_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STRINGS; i++) begin
                tuning_reg[i] <= fnp_pkg::tuning_reset(i);
            end
            capo_reg <= '0;
        end else if (cfg_we) begin
            for (int i = 0; i < NUM_STRINGS; i++) begin
                if (tuning_hit && cfg_idx == 3'(i)) begin
                    tuning_reg[i] <= pwdata[6:0];
                end
            end
            if (capo_ok) begin
                capo_reg <= pwdata[4:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (tuning_hit) begin
            prdata = 32'(tuning_reg[cfg_idx[SIW-1:0]]);
        end else if (cfg_idx == fnp_pkg::CAPO_REG) begin
            prdata = 32'(capo_reg);
        end
    end

    // datapath
    fnp_row_mem #(
        .DEPTH  (NUM_STRINGS),
        .WIDTH  (RW),
        .ADDR_W (SIW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (cfg_clr),
        .we      (mem_we),
        .waddr   (addr_reg),
        .wdata   (new_row),
        .raddr   (addr_reg),
        .rdata   (row)
    );

    assign mod_fret = (func_reg == fnp_pkg::FUNC_READ) ? fsel_reg : best_fret_reg;

    fnp_string_unit #(
        .FRET_COUNT   (FRET_COUNT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_unit (
        .func      (func_reg),
        .ch        (ch_reg),
        .note      (note_reg),
        .tuning    (tuning_reg[addr_reg]),
        .capo      (capo_reg),
        .mod_fret  (mod_fret),
        .row       (row),
        .eval      (eval),
        .new_row   (new_row),
        .cell_data (cell_data)
    );

    // sequencer
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign m_xfer   = m_valid && m_ready;
    assign last     = (addr_reg == SIW'(NUM_STRINGS - 1));
    assign key_now  = {eval.busy, eval.fret};
    assign better   = eval.ok && (!found_reg || key_now < best_key_reg);
    assign in_range = {1'b0, s_string_sel} < 4'(NUM_STRINGS)
                      && {1'b0, s_fret_sel} < 6'(FRET_COUNT);
    assign mem_we   = (state_reg == ST_BWR)
                      || (state_reg == ST_EV
                          && (func_reg == fnp_pkg::FUNC_NOTE_OFF
                              || func_reg == fnp_pkg::FUNC_ALL_OFF));

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        found_next     = found_reg;
        best_str_next  = best_str_reg;
        best_fret_next = best_fret_reg;
        best_key_next  = best_key_reg;
        cell_next      = cell_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    found_next     = 1'b0;
                    best_str_next  = '0;
                    best_fret_next = '0;
                    best_key_next  = '0;
                    cell_next      = '0;
                    addr_next      = '0;
                    state_next     = ST_RD;
                    if (s_func == fnp_pkg::FUNC_READ) begin
                        if (in_range) begin
                            addr_next = s_string_sel[SIW-1:0];
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                if (func_reg == fnp_pkg::FUNC_READ) begin
                    cell_next  = cell_data;
                    state_next = ST_OUT;
                end else begin
                    if (func_reg == fnp_pkg::FUNC_NOTE_ON && better) begin
                        found_next     = 1'b1;
                        best_str_next  = addr_reg;
                        best_fret_next = eval.fret;
                        best_key_next  = key_now;
                    end
                    if (!last) begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = ST_RD;
                    end else if (func_reg == fnp_pkg::FUNC_NOTE_ON && found_next) begin
                        addr_next  = best_str_next;
                        state_next = ST_BRD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_BRD: begin
                state_next = ST_BWR;
            end
            ST_BWR: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
            addr_reg  <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            addr_reg  <= addr_next;
            if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
            end else if (m_xfer) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_str_reg  <= best_str_next;
        best_fret_reg <= best_fret_next;
        best_key_reg  <= best_key_next;
        cell_reg      <= cell_next;
        if (s_xfer) begin
            func_reg <= s_func;
            ch_reg   <= s_channels[CHANNEL_BITS-1:0];
            note_reg <= s_note;
            fsel_reg <= s_fret_sel;
        end
        if (state_reg == ST_OUT && (!m_valid || m_ready)) begin
            m_placed     <= found_reg;
            m_string_out <= 3'(best_str_reg);
            m_fret_out   <= best_fret_reg;
            m_cell_mask  <= 16'(cell_reg);
        end
    end

`ifndef ASSERT_OFF
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_EV || state_reg == ST_BWR))
        else $error("row write outside evaluate or write-back");

    a_place_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_placed) |->
            ({1'b0, m_string_out} < 4'(NUM_STRINGS)
             && {1'b0, m_fret_out} < 6'(FRET_COUNT)))
        else $error("placement outside the board");

    a_place_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cell_mask != '0) |-> !m_placed)
        else $error("cell mask reported with a placement");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_ready)
        else $error("input taken while an event is in progress");
`endif

endmodule

FILE: test/fretboard_note_placement_top_tb.sv
// Testbench for fretboard_note_placement_top: directed and random events checked against a predictor or given results.
module fretboard_note_placement_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRINGS     = 6;
    localparam int FRETS       = 25;
    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 40;
    localparam int SPARE_REG   = 7;
    localparam int N_DIR       = 23;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] channels;
        logic [6:0]  note;
        logic [2:0]  string_sel;
        logic [4:0]  fret_sel;
    } note_event_t;

    typedef struct packed {
        logic        placed;
        logic [2:0]  string_out;
        logic [4:0]  fret_out;
        logic [15:0] cell_mask;
    } placement_t;

    typedef struct packed {
        note_event_t ev;
        logic        given;
        placement_t  res;
    } plan_row_t;

    localparam placement_t NOTHING = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [15:0] s_channels = '0;
    logic [6:0]  s_note = '0;
    logic [2:0]  s_string_sel = '0;
    logic [4:0]  s_fret_sel = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_placed;
    logic [2:0]  m_string_out;
    logic [4:0]  m_fret_out;
    logic [15:0] m_cell_mask;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state
    logic [15:0] board [STRINGS][FRETS];
    logic [6:0]  tuning [STRINGS];
    logic [4:0]  capo_pos;
    placement_t  placements_due[$];

    logic [6:0]  last_note = '0;
    logic [2:0]  last_string = '0;
    logic [4:0]  last_fret = '0;

    int errors = 0;
    int cycles = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    fretboard_note_placement_top dut (.*);

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void clear_board();
        foreach (board[s, f]) board[s][f] = '0;
    endfunction

    function automatic void enqueue_result(input placement_t res);
        placements_due = {placements_due, res};
    endfunction

    function automatic bit fret_for(input int s, input logic [6:0] note,
                                    output logic [4:0] fret);
        int f;
        f = int'(note) - int'(tuning[s]);
        fret = f[4:0];
        return (f >= int'(capo_pos)) && (f < FRETS);
    endfunction

    function automatic placement_t place_note(input note_event_t ev);
        placement_t  res;
        logic [4:0]  fret;
        bit          found;
        bit          busy;
        int          best;
        int          key;
        res = '0;
        found = 1'b0;
        best = 0;
        case (ev.func)
            fnp_pkg::FUNC_NOTE_ON: begin
                for (int s = 0; s < STRINGS; s++) begin
                    if (fret_for(s, ev.note, fret)) begin
                        busy = 1'b0;
                        for (int f = 0; f < FRETS; f++)
                            if ((board[s][f] & ev.channels) != '0) busy = 1'b1;
                        key = (int'(busy) << 8) | int'(fret);
                        if (!found || key < best) begin
                            found = 1'b1;
                            best = key;
                            res.string_out = s[2:0];
                            res.fret_out = fret;
                        end
                    end
                end
                if (found) begin
                    res.placed = 1'b1;
                    board[res.string_out][res.fret_out] |= ev.channels;
                    last_note = ev.note;
                    last_string = res.string_out;
                    last_fret = res.fret_out;
                end
            end
            fnp_pkg::FUNC_NOTE_OFF: begin
                for (int s = 0; s < STRINGS; s++)
                    if (fret_for(s, ev.note, fret)) board[s][fret] &= ~ev.channels;
            end
            fnp_pkg::FUNC_ALL_OFF: begin
                foreach (board[s, f]) board[s][f] &= ~ev.channels;
            end
            fnp_pkg::FUNC_READ: begin
                if (ev.string_sel < STRINGS && ev.fret_sel < FRETS)
                    res.cell_mask = board[ev.string_sel][ev.fret_sel];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void apply_reg(input int idx, input logic [31:0] val);
        if (idx < fnp_pkg::TUNING_REGS) begin
            tuning[idx] = val[6:0];
            clear_board();
        end else if (idx == int'(fnp_pkg::CAPO_REG) && val[4:0] < FRETS) begin
            capo_pos = val[4:0];
            clear_board();
        end
    endfunction

    // mostly playable notes on few channels so that strings get busy
    function automatic note_event_t random_event();
        note_event_t ev;
        int pick;
        int s;
        int n;
        pick = $urandom_range(0, 99);
        ev.func = pick < 45 ? fnp_pkg::FUNC_NOTE_ON : pick < 65 ? fnp_pkg::FUNC_NOTE_OFF :
                  pick < 70 ? fnp_pkg::FUNC_ALL_OFF : fnp_pkg::FUNC_READ;
        pick = $urandom_range(0, 9);
        if (pick < 5) ev.channels = 16'(1) << $urandom_range(0, 3);
        else if (pick < 8) ev.channels = 16'($urandom_range(0, 15));
        else ev.channels = 16'($urandom);
        s = $urandom_range(0, STRINGS - 1);
        n = int'(tuning[s]) + int'($urandom_range(int'(capo_pos), FRETS - 1));
        if (ev.func == fnp_pkg::FUNC_NOTE_OFF && $urandom_range(0, 1) == 1)
            n = int'(last_note);
        else if ($urandom_range(0, 99) < 15 || n > 127) n = $urandom_range(0, 127);
        ev.note = 7'(n);
        ev.string_sel = 3'($urandom_range(0, 7));
        ev.fret_sel = 5'($urandom_range(0, 31));
        if (ev.func == fnp_pkg::FUNC_READ) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                ev.string_sel = last_string;
                ev.fret_sel = last_fret;
            end else if (pick < 90) begin
                ev.string_sel = 3'($urandom_range(0, STRINGS - 1));
                ev.fret_sel = 5'($urandom_range(0, FRETS - 1));
            end
        end
        return ev;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge aclk) begin
        placement_t want;
        if (aresetn && m_valid && m_ready) begin
            if (placements_due.size() == 0) begin
                $display("%0t: unexpected transfer, placed %0d string %0d fret %0d mask %h",
                         $time, m_placed, m_string_out, m_fret_out, m_cell_mask);
                errors++;
            end else begin
                want = placements_due.pop_front();
                check_field("placed", 16'(want.placed), 16'(m_placed));
                check_field("string_out", 16'(want.string_out), 16'(m_string_out));
                check_field("fret_out", 16'(want.fret_out), 16'(m_fret_out));
                check_field("cell_mask", want.cell_mask, m_cell_mask);
            end
        end
    end

    task automatic send_event(input note_event_t ev, input logic given, input placement_t res);
        placement_t predicted;
        while (!steady && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= ev.func;
        s_channels <= ev.channels;
        s_note <= ev.note;
        s_string_sel <= ev.string_sel;
        s_fret_sel <= ev.fret_sel;
        do @(posedge aclk); while (!s_ready);
        predicted = place_note(ev);
        enqueue_result(given ? res : predicted);
        @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_event(random_event(), 1'b0, NOTHING);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (placements_due.size() != 0);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic reg_check(input int idx);
        logic [31:0] want;
        want = (idx < fnp_pkg::TUNING_REGS) ? 32'(tuning[idx]) : 32'(capo_pos);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 5'(idx * 4);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d read back, expected %h, got %h",
                     $time, idx, want, prdata);
            errors++;
        end
        @(negedge aclk);
    endtask

    task automatic retune(input logic [STRINGS-1:0][6:0] tunes, input logic [4:0] capo_set);
        drain();
        for (int i = 0; i < STRINGS; i++) reg_write(i, 32'(tunes[i]));
        reg_write(int'(fnp_pkg::CAPO_REG), 32'(capo_set));
        for (int i = 0; i <= int'(fnp_pkg::CAPO_REG); i++) reg_check(i);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // capo beyond the board and an unmapped address: board must survive
    task automatic stray_writes();
        drain();
        reg_write(int'(fnp_pkg::CAPO_REG), 32'd31);
        reg_write(int'(fnp_pkg::CAPO_REG), 32'd25);
        reg_write(SPARE_REG, $urandom);
        reg_check(int'(fnp_pkg::CAPO_REG));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [STRINGS-1:0][6:0] tunes;
        plan_row_t plan [N_DIR];
        plan = '{
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd0, 5'd0}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h0001, 7'd40, 3'd0, 5'd0}, 1'b1,
              '{1'b1, 3'd0, 5'd0, 16'h0}},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd0, 5'd0}, 1'b1,
              '{1'b0, 3'd0, 5'd0, 16'h1}},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h0001, 7'd64, 3'd0, 5'd0}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h0002, 7'd45, 3'd0, 5'd0}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h0003, 7'd45, 3'd0, 5'd0}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'hFFFF, 7'd127, 3'd7, 5'd31}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'hFFFF, 7'd0, 3'd0, 5'd0}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h8000, 7'd88, 3'd0, 5'd0}, 1'b1,
              '{1'b1, 3'd5, 5'd24, 16'h0}},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd5, 5'd24}, 1'b1,
              '{1'b0, 3'd0, 5'd0, 16'h8000}},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h0000, 7'd50, 3'd0, 5'd0}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd1, 5'd0}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_OFF, 16'h0001, 7'd45, 3'd7, 5'd31}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd1, 5'd0}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_OFF, 16'hFFFF, 7'd127, 3'd0, 5'd0}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_ALL_OFF, 16'h7FFF, 7'd127, 3'd0, 5'd0}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd5, 5'd24}, 1'b0, NOTHING},
            '{'{fnp_pkg::FUNC_ALL_OFF, 16'hFFFF, 7'd0, 3'd7, 5'd31}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd5, 5'd24}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd6, 5'd0}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'hFFFF, 7'd127, 3'd7, 5'd31}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_READ, 16'h0000, 7'd0, 3'd0, 5'd25}, 1'b1, NOTHING},
            '{'{fnp_pkg::FUNC_NOTE_ON, 16'h0001, 7'd40, 3'd0, 5'd0}, 1'b1,
              '{1'b1, 3'd0, 5'd0, 16'h0}}
        };
        tuning = '{7'd40, 7'd45, 7'd50, 7'd55, 7'd59, 7'd64};
        capo_pos = '0;
        clear_board();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int i = 0; i <= int'(fnp_pkg::CAPO_REG); i++) reg_check(i);
        psel <= 1'b0;
        penable <= 1'b0;

        foreach (plan[i]) send_event(plan[i].ev, plan[i].given, plan[i].res);

        // receiver stalls for a long stretch while events keep coming
        hold_req = 1'b1;
        run_random(200);

        foreach (tunes[i]) tunes[i] = 7'($urandom_range(0, 127));
        retune(tunes, 5'($urandom_range(0, FRETS - 1)));
        run_random(170);

        retune('0, 5'd24);
        run_random(100);

        retune({STRINGS{7'd127}}, 5'd0);
        run_random(60);

        steady = 1'b1;
        retune({7'd64, 7'd59, 7'd55, 7'd50, 7'd45, 7'd40}, 5'($urandom_range(1, 5)));
        run_random(100);
        stray_writes();
        run_random(100);
        steady = 1'b0;

        retune({STRINGS{7'd60}}, 5'd0);
        run_random(75);
        drain();
        run_random(75);

        foreach (tunes[i]) tunes[i] = 7'($urandom_range(30, 70));
        retune(tunes, 5'd0);
        run_random(170);

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
sv/fnp_pkg.sv
sv/fnp_row_mem.sv
sv/fnp_string_unit.sv
sv/fretboard_note_placement_top.sv
test/fretboard_note_placement_top_tb.sv
